### rtl/olist_pkg.sv
package olist_pkg;

	localparam logic [2:0] KIND_APPEND       = 3'd0;
	localparam logic [2:0] KIND_PREPEND      = 3'd1;
	localparam logic [2:0] KIND_REMOVE_LAST  = 3'd2;
	localparam logic [2:0] KIND_REMOVE_FIRST = 3'd3;
	localparam logic [2:0] KIND_INSERT       = 3'd4;
	localparam logic [2:0] KIND_ERASE        = 3'd5;
	localparam logic [2:0] KIND_FIND         = 3'd6;
	localparam logic [2:0] KIND_READ         = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic load;
		logic from_lower;
		logic from_upper;
	} cell_cmd_t;

endpackage

### rtl/olist_cell.sv
module olist_cell
	import olist_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  cell_cmd_t                   cmd,
	input  logic signed [WORD_BITS-1:0] key,
	input  logic signed [WORD_BITS-1:0] lower,
	input  logic signed [WORD_BITS-1:0] upper,
	output logic signed [WORD_BITS-1:0] word,
	output logic                        match
);

	logic signed [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= key;
		end else if (cmd.from_lower) begin
			word_q <= lower;
		end else if (cmd.from_upper) begin
			word_q <= upper;
		end
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

### rtl/ordered_array_list_top.sv
// channel | dir | tdata (low bit up)                   | tuser
// s_*     | in  | position[4:0], value[36:5]           | kind[2:0]
// m_*     | out | status[2:0], found_index[6:3],       | -
//         |     | read_value[38:7], count[43:39]       |
// An item is registered on accept and executed from that register against the cell row.
// One item per cycle while the result register drains; a stalled m_tready holds the
// executing item, and s_tready drops until it retires.
// Reset clears the entry count and valid flags; entries stay undefined until written.
module ordered_array_list_top
	import olist_pkg::*;
#(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position, value
	input  logic [2:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status, found_index, read_value, count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 5) ? CW : 5;
	localparam int IW = $clog2(CAPACITY);

	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic [4:0]         pos_s1;
	logic signed [31:0] val_s1;

	logic [CW-1:0] count_q;
	logic          m_valid_q;
	logic [2:0]    status_q;
	logic [3:0]    found_q;
	logic [31:0]   rdv_q;
	logic [4:0]    cnt_q;

	logic                        fire;
	logic [XW-1:0]               nx;
	logic [XW-1:0]               pos_x;
	logic [XW-1:0]               eff_pos;
	logic                        is_ins;
	logic                        is_rem;
	logic                        is_find;
	logic [2:0]                  status_d;
	logic signed [WORD_BITS-1:0] key;
	logic signed [WORD_BITS-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]         match;
	logic [CAPACITY-1:0]         hit;
	logic                        any_hit;
	logic [IW-1:0]               hit_idx;
	logic signed [WORD_BITS-1:0] rd_word;
	logic                        do_ins;
	logic                        do_rem;

	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign nx       = XW'(count_q);
	assign pos_x    = XW'(pos_s1);
	assign key      = WORD_BITS'(val_s1);

	always_comb begin
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		is_find = 1'b0;
		eff_pos = pos_x;
		unique case (kind_s1) inside
			KIND_APPEND: begin
				is_ins  = 1'b1;
				eff_pos = nx;
			end
			KIND_PREPEND: begin
				is_ins  = 1'b1;
				eff_pos = '0;
			end
			KIND_INSERT: begin
				is_ins = 1'b1;
			end
			KIND_REMOVE_LAST: begin
				is_rem  = 1'b1;
				eff_pos = nx - 1'b1;
			end
			KIND_REMOVE_FIRST: begin
				is_rem  = 1'b1;
				eff_pos = '0;
			end
			KIND_ERASE: begin
				is_rem = 1'b1;
			end
			KIND_FIND: begin
				is_find = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (is_ins) begin
			if (nx == XW'(CAPACITY)) begin
				status_d = ST_FULL;
			end else if (kind_s1 == KIND_INSERT && pos_x > nx) begin
				status_d = ST_BADPOS;
			end else begin
				status_d = ST_OK;
			end
		end else if (is_find) begin
			status_d = any_hit ? ST_OK : ST_NOTFOUND;
		end else if (nx == '0) begin
			status_d = ST_EMPTY;
		end else if ((kind_s1 == KIND_ERASE || kind_s1 == KIND_READ) && pos_x >= nx) begin
			status_d = ST_BADPOS;
		end else begin
			status_d = ST_OK;
		end
	end

	assign do_ins = fire && is_ins && (status_d == ST_OK);
	assign do_rem = fire && is_rem && (status_d == ST_OK);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [XW-1:0] IDX  = XW'(i);
		localparam logic [XW-1:0] IDX1 = XW'(i + 1);
		cell_cmd_t                   cmd;
		logic signed [WORD_BITS-1:0] lower;
		logic signed [WORD_BITS-1:0] upper;

		assign cmd.load       = do_ins && (IDX == eff_pos);
		assign cmd.from_lower = do_ins && (IDX > eff_pos) && (IDX <= nx);
		assign cmd.from_upper = do_rem && (IDX >= eff_pos) && (IDX1 < nx);
		assign hit[i]         = match[i] && (IDX < nx);

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = words[i+1];
		end

		olist_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.key  (key),
			.lower(lower),
			.upper(upper),
			.word (words[i]),
			.match(match[i])
		);
	end

	always_comb begin
		hit_idx = '0;
		rd_word = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IW'(i);
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (XW'(i) == eff_pos) begin
				rd_word = words[i];
			end
		end
	end
	assign any_hit = |hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			pos_s1  <= s_tdata[4:0];
			val_s1  <= s_tdata[36:5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			found_q  <= (is_find && any_hit) ? 4'(hit_idx) : 4'd0;
			rdv_q    <= (!is_ins && !is_find && status_d == ST_OK) ? 32'(rd_word) : 32'd0;
			if (do_ins) begin
				cnt_q <= 5'(nx + 1'b1);
			end else if (do_rem) begin
				cnt_q <= 5'(nx - 1'b1);
			end else begin
				cnt_q <= 5'(nx);
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, cnt_q, rdv_q, found_q, status_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d != ST_OK |=> count_q == $past(count_q))
		else $error("failed request changed the count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d != ST_OK |=> rdv_q == 32'd0 && found_q == 4'd0)
		else $error("failed request returned data");

endmodule

### verif/ordered_array_list_top_test.sv
`default_nettype none

module ordered_array_list_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import olist_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int MAX_POS     = 16;
	localparam int MAX_WAIT    = 18;
	localparam int STUCK_LIMIT = 1000;
	localparam int N_RANDOM    = 550;

	typedef struct {
		logic [2:0]         kind;
		logic [4:0]         position;
		logic signed [31:0] value;
		int                 gap;
		bit                 drain;
	} list_request_t;

	typedef struct packed {
		logic [4:0]  count;
		logic [31:0] read_value;
		logic [3:0]  found_index;
		logic [2:0]  status;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // position[4:0], value[36:5]
	logic [2:0]  s_tuser = '0;   // kind[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // status[2:0], found_index[6:3], read_value[38:7], count[43:39]

	list_request_t pending_q[$];
	list_result_t  expected_q[$];
	list_request_t cur_req;

	logic [31:0] list_mem[LIST_DEPTH];
	int          list_len = 0;

	int idle_run = 0;
	int stall_left = 0;
	int stuck = 0;
	int n_sent = 0;
	int n_checked = 0;
	int errors = 0;
	int status_seen[5] = '{default: 0};

	ordered_array_list_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// list behavior: updates the shadow list and returns the expected result
	function automatic list_result_t apply_request(list_request_t r);
		list_result_t res;
		int p;
		res = '0;
		case (r.kind)
			KIND_APPEND, KIND_PREPEND, KIND_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (r.kind == KIND_APPEND)
						p = list_len;
					else if (r.kind == KIND_PREPEND)
						p = 0;
					else
						p = int'(r.position);
					if (p > list_len) begin
						res.status = ST_BADPOS;
					end else begin
						for (int i = list_len; i > p; i--)
							list_mem[i] = list_mem[i - 1];
						list_mem[p] = r.value;
						list_len++;
					end
				end
			end
			KIND_REMOVE_LAST, KIND_REMOVE_FIRST, KIND_ERASE, KIND_READ: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else begin
					if (r.kind == KIND_REMOVE_LAST)
						p = list_len - 1;
					else if (r.kind == KIND_REMOVE_FIRST)
						p = 0;
					else
						p = int'(r.position);
					if (p >= list_len) begin
						res.status = ST_BADPOS;
					end else begin
						res.read_value = list_mem[p];
						if (r.kind != KIND_READ) begin
							for (int i = p; i + 1 < list_len; i++)
								list_mem[i] = list_mem[i + 1];
							list_len--;
						end
					end
				end
			end
			KIND_FIND: begin
				res.status = ST_NOTFOUND;
				for (int i = 0; i < list_len; i++) begin
					if (res.status == ST_NOTFOUND && list_mem[i] == r.value) begin
						res.status = ST_OK;
						res.found_index = i[3:0];
					end
				end
			end
		endcase
		res.count = list_len[4:0];
		return res;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] pool[8];
		pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h7};
		if ($urandom_range(0, 1) == 0)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic queue_item(logic [2:0] kind, logic [4:0] position, logic [31:0] value,
			int gap, bit drain);
		list_request_t r;
		r.kind = kind;
		r.position = position;
		r.value = value;
		r.gap = gap;
		r.drain = drain;
		pending_q.push_back(r);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			idle_run = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(apply_request(cur_req));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() != 0 && idle_run >= pending_q[0].gap &&
						!(pending_q[0].drain && expected_q.size() != 0)) begin
					cur_req = pending_q.pop_front();
					s_tdata <= {3'b000, cur_req.value, cur_req.position};
					s_tuser <= cur_req.kind;
					s_tvalid <= 1'b1;
					idle_run = 0;
				end else begin
					s_tvalid <= 1'b0;
					idle_run++;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[43:0];
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("found_index", 32'(want.found_index), 32'(got.found_index));
					check_field("read_value", want.read_value, got.read_value);
					check_field("count", 32'(want.count), 32'(got.count));
					if (want.status <= ST_NOTFOUND)
						status_seen[want.status]++;
				end
				n_checked++;
				stall_left = ((n_checked / 45) % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck <= 0;
		end else if (stuck >= STUCK_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	initial begin
		int gap;
		int r;
		logic [2:0] kind;

		// empty list
		queue_item(KIND_READ, 5'd0, 32'h1, 0, 0);
		queue_item(KIND_REMOVE_LAST, 5'd0, 32'h0, 0, 0);
		queue_item(KIND_REMOVE_FIRST, 5'd0, 32'h0, 3, 0);
		queue_item(KIND_ERASE, 5'd0, 32'h0, 0, 0);
		queue_item(KIND_FIND, 5'd0, 32'h0, 0, 0);
		queue_item(KIND_INSERT, 5'd1, 32'h5, 1, 0);
		// fill to capacity; insert at the current count appends
		for (int i = 0; i < LIST_DEPTH; i++) begin
			case (i % 4)
				0: kind = KIND_INSERT;
				1: kind = KIND_APPEND;
				2: kind = KIND_PREPEND;
				default: kind = KIND_INSERT;
			endcase
			queue_item(kind, (i % 4 == 0) ? 5'(i) : 5'(i / 2),
				(i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff :
				(i == 2) ? 32'hffff_ffff : 32'(i * 32'h0101_0101), i % 3, 0);
		end
		// full list
		queue_item(KIND_APPEND, 5'd0, 32'h1234_5678, 0, 0);
		queue_item(KIND_INSERT, 5'd16, 32'hdead_beef, 0, 0);
		queue_item(KIND_PREPEND, 5'd31, 32'h0, 0, 0);
		// bad positions and hits
		queue_item(KIND_READ, 5'd15, 32'h0, 0, 0);
		queue_item(KIND_READ, 5'd16, 32'h0, 0, 0);
		queue_item(KIND_FIND, 5'd0, 32'h7fff_ffff, 0, 0);
		queue_item(KIND_ERASE, 5'd0, 32'h0, 2, 0);
		queue_item(KIND_REMOVE_LAST, 5'd0, 32'h0, 0, 0);
		queue_item(KIND_REMOVE_FIRST, 5'd0, 32'h0, 0, 0);

		// random: phases that grow, shrink and mix
		for (int n = 0; n < N_RANDOM; n++) begin
			r = $urandom_range(0, 9);
			case ((n / 55) % 3)
				0: kind = (r < 3) ? KIND_APPEND : (r < 5) ? KIND_PREPEND :
					(r < 7) ? KIND_INSERT : (r == 7) ? KIND_FIND :
					(r == 8) ? KIND_READ : 3'($urandom_range(2, 5));
				1: kind = (r < 2) ? KIND_REMOVE_LAST : (r < 4) ? KIND_REMOVE_FIRST :
					(r < 6) ? KIND_ERASE : (r == 6) ? KIND_FIND :
					(r == 7) ? KIND_READ : (r == 8) ? KIND_APPEND : KIND_INSERT;
				default: kind = 3'($urandom_range(0, 7));
			endcase
			gap = ((n / 37) % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
			queue_item(kind, 5'($urandom_range(0, MAX_POS)), pick_value(), gap,
				(n == 0) || ($urandom_range(0, 39) == 0));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests sent, %0d results checked", n_sent, n_checked);
		$display("status ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
